// ===== src/pwts_pkg.sv =====
`timescale 1ns / 1ps

package pwts_pkg;

   localparam int COORD_W   = 20;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int AXIS_W    = 16;
   localparam int PROD_W    = DIFF_W + AXIS_W;
   localparam int DOT_W     = PROD_W + 2;
   localparam int MAG_W     = DOT_W - 1;
   localparam int SCALE_W   = 20;
   localparam int CENTER_W  = 12;
   localparam int MUL_W     = MAG_W + SCALE_W;
   localparam int NUM_W     = MUL_W - 4;
   localparam int QBITS     = 21;
   localparam int CMP_W     = MAG_W + QBITS + 1;
   localparam int OUT_W     = 20;
   localparam int SUM_W     = 24;
   localparam int ORIGIN_W  = 3 * COORD_W;
   localparam int AXES_W    = 3 * AXIS_W;
   localparam int DEPTH_MIN = (1 << 14) / 1000;

   localparam int PRE_STAGES = 5;

   typedef logic [2:0] reg_index_type;

   localparam reg_index_type REG_ORIGIN   = 3'd0;
   localparam reg_index_type REG_FORWARD  = 3'd1;
   localparam reg_index_type REG_LEFT     = 3'd2;
   localparam reg_index_type REG_UP       = 3'd3;
   localparam reg_index_type REG_SCALE_X  = 3'd4;
   localparam reg_index_type REG_SCALE_Y  = 3'd5;
   localparam reg_index_type REG_CENTER_X = 3'd6;
   localparam reg_index_type REG_CENTER_Y = 3'd7;

endpackage

// ===== src/perspective_world_to_screen.sv =====
`timescale 1ns / 1ps

// Perspective world-to-screen projection.
// Requests arrive on req_* (one world point in tdata); results leave on rsp_*
// (screen x and y in 1/16 pixel in tdata, in-front flag in tuser).
// One result for every request, in order.
// View origin, axes, scales and centers are written over the csr_* port;
// the user must write them only while no request is in flight, as the block
// does not enforce this. Reads return the stored values.
// Steps: origin subtract, axis products, dot sums, magnitude and scale
// multiply, quotient overflow check, restoring division with one quotient
// bit per stage, saturation.
// Throughput: one request per cycle while the output is not stalled; both
// screen axes have their own divider pipeline.
// When rsp_tready is low with a result waiting, the whole pipeline holds and
// req_tready goes low; nothing is lost or repeated.
// Reset clears all valid bits and loads the default view: origin 0,
// forward x, left y, up z, scales 320.0, center 320,240.

module perspective_world_to_screen import pwts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // point_x, point_y, point_z, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // screen_x, screen_y
   output logic [0:0]  rsp_tuser,   // in_front
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   // configuration
   logic [ORIGIN_W-1:0] origin_ff;
   logic [AXES_W-1:0]   axis_ff   [3];
   logic [SCALE_W-1:0]  scale_ff  [2];
   logic [CENTER_W-1:0] center_ff [2];
   reg_index_type       csr_idx;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[5:3];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff    <= '0;
         axis_ff[0]   <= AXES_W'(64'd16384);
         axis_ff[1]   <= AXES_W'(64'd1073741824);
         axis_ff[2]   <= AXES_W'(64'd70368744177664);
         scale_ff[0]  <= SCALE_W'(81920);
         scale_ff[1]  <= SCALE_W'(81920);
         center_ff[0] <= CENTER_W'(320);
         center_ff[1] <= CENTER_W'(240);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ORIGIN:   origin_ff    <= csr_pwdata[ORIGIN_W-1:0];
            REG_FORWARD:  axis_ff[0]   <= csr_pwdata[AXES_W-1:0];
            REG_LEFT:     axis_ff[1]   <= csr_pwdata[AXES_W-1:0];
            REG_UP:       axis_ff[2]   <= csr_pwdata[AXES_W-1:0];
            REG_SCALE_X:  scale_ff[0]  <= csr_pwdata[SCALE_W-1:0];
            REG_SCALE_Y:  scale_ff[1]  <= csr_pwdata[SCALE_W-1:0];
            REG_CENTER_X: center_ff[0] <= csr_pwdata[CENTER_W-1:0];
            REG_CENTER_Y: center_ff[1] <= csr_pwdata[CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ORIGIN:   csr_prdata = 64'(origin_ff);
         REG_FORWARD:  csr_prdata = 64'(axis_ff[0]);
         REG_LEFT:     csr_prdata = 64'(axis_ff[1]);
         REG_UP:       csr_prdata = 64'(axis_ff[2]);
         REG_SCALE_X:  csr_prdata = 64'(scale_ff[0]);
         REG_SCALE_Y:  csr_prdata = 64'(scale_ff[1]);
         REG_CENTER_X: csr_prdata = 64'(center_ff[0]);
         REG_CENTER_Y: csr_prdata = 64'(center_ff[1]);
         default:      csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic en;
   logic out_valid_ff;

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   logic pv_ff [PRE_STAGES];
   logic dv_ff [QBITS+1];

   // stage 1: subtract origin
   logic signed [DIFF_W-1:0] diff_ff [3];
   logic signed [DIFF_W-1:0] diff_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff_in[k] = DIFF_W'(signed'(req_tdata[k*COORD_W +: COORD_W]))
                    - DIFF_W'(signed'(origin_ff[k*COORD_W +: COORD_W]));
      end
   end

   // stage 2: axis products
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[a][k] = PROD_W'(diff_ff[k])
                          * PROD_W'(signed'(axis_ff[a][k*AXIS_W +: AXIS_W]));
         end
      end
   end

   // stage 3: dot sums (depth, left, up)
   logic signed [DOT_W-1:0] dot_ff [3];
   logic signed [DOT_W-1:0] dot_in [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         dot_in[a] = DOT_W'(prod_ff[a][0]) + DOT_W'(prod_ff[a][1])
                   + DOT_W'(prod_ff[a][2]);
      end
   end

   // stage 4: front test, magnitudes
   logic             front4_ff, front4_in;
   logic [MAG_W-1:0] depth4_ff, depth4_in;
   logic [MAG_W-1:0] mag4_ff [2];
   logic [MAG_W-1:0] mag4_in [2];
   logic             neg4_ff [2];
   logic             neg4_in [2];

   always_comb begin
      front4_in = !dot_ff[0][DOT_W-1]
               && (dot_ff[0][DOT_W-2:0] > (DOT_W-1)'(DEPTH_MIN));
      depth4_in = dot_ff[0][MAG_W-1:0];
      for (int l = 0; l < 2; l++) begin
         neg4_in[l] = dot_ff[l+1][DOT_W-1];
         mag4_in[l] = neg4_in[l] ? MAG_W'(-dot_ff[l+1]) : MAG_W'(dot_ff[l+1]);
      end
   end

   // stage 5: scale multiply
   logic             front5_ff;
   logic [MAG_W-1:0] depth5_ff;
   logic             neg5_ff [2];
   logic [MUL_W-1:0] mul5_ff [2];
   logic [MUL_W-1:0] mul5_in [2];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         mul5_in[l] = MUL_W'(mag4_ff[l]) * MUL_W'(scale_ff[l]);
      end
   end

   // divider: stage 0 overflow check, then one quotient bit per stage
   logic [NUM_W-1:0] rem_ff   [QBITS+1][2];
   logic [NUM_W-1:0] rem_in   [QBITS+1][2];
   logic [QBITS-1:0] q_ff     [QBITS+1][2];
   logic [QBITS-1:0] q_in     [QBITS+1][2];
   logic             sat_ff   [QBITS+1][2];
   logic             sat_in   [QBITS+1][2];
   logic             neg_ff   [QBITS+1][2];
   logic             neg_in   [QBITS+1][2];
   logic             front_ff [QBITS+1];
   logic             front_in [QBITS+1];
   logic [MAG_W-1:0] depth_ff [QBITS+1];
   logic [MAG_W-1:0] depth_in [QBITS+1];

   always_comb begin
      logic [CMP_W-1:0] dsh;
      logic             ge;
      dsh = CMP_W'(depth5_ff) << QBITS;
      front_in[0] = front5_ff;
      depth_in[0] = depth5_ff;
      for (int l = 0; l < 2; l++) begin
         rem_in[0][l] = mul5_ff[l][MUL_W-1:4];
         q_in[0][l]   = '0;
         neg_in[0][l] = neg5_ff[l];
         sat_in[0][l] = CMP_W'(mul5_ff[l][MUL_W-1:4]) >= dsh;
      end
      for (int j = 0; j < QBITS; j++) begin
         front_in[j+1] = front_ff[j];
         depth_in[j+1] = depth_ff[j];
         dsh = CMP_W'(depth_ff[j]) << (QBITS - 1 - j);
         for (int l = 0; l < 2; l++) begin
            ge = CMP_W'(rem_ff[j][l]) >= dsh;
            rem_in[j+1][l] = ge ? (rem_ff[j][l] - dsh[NUM_W-1:0]) : rem_ff[j][l];
            q_in[j+1][l]   = q_ff[j][l] | (QBITS'(ge) << (QBITS - 1 - j));
            neg_in[j+1][l] = neg_ff[j][l];
            sat_in[j+1][l] = sat_ff[j][l];
         end
      end
   end

   // final: sign, subtract from center, saturate; zero when not in front
   logic [OUT_W-1:0] out_ff [2];
   logic [OUT_W-1:0] out_in [2];
   logic             out_front_ff;

   localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(1 << (OUT_W - 1));

   always_comb begin
      logic signed [SUM_W-1:0] qs;
      logic signed [SUM_W-1:0] sv;
      for (int l = 0; l < 2; l++) begin
         qs = sat_ff[QBITS][l] ? (SUM_W'(1) << QBITS) : SUM_W'(q_ff[QBITS][l]);
         if (neg_ff[QBITS][l]) begin
            qs = -qs;
         end
         sv = SUM_W'({center_ff[l], 4'b0000}) - qs;
         if (!front_ff[QBITS]) begin
            out_in[l] = '0;
         end else if (sv > OUT_MAX) begin
            out_in[l] = OUT_MAX[OUT_W-1:0];
         end else if (sv < OUT_MIN) begin
            out_in[l] = OUT_MIN[OUT_W-1:0];
         end else begin
            out_in[l] = sv[OUT_W-1:0];
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PRE_STAGES; s++) pv_ff[s] <= 1'b0;
         for (int j = 0; j <= QBITS; j++) dv_ff[j] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         pv_ff[0] <= req_tvalid;
         for (int s = 1; s < PRE_STAGES; s++) pv_ff[s] <= pv_ff[s-1];
         dv_ff[0] <= pv_ff[PRE_STAGES-1];
         for (int j = 1; j <= QBITS; j++) dv_ff[j] <= dv_ff[j-1];
         out_valid_ff <= dv_ff[QBITS];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff   <= diff_in;
         prod_ff   <= prod_in;
         dot_ff    <= dot_in;
         front4_ff <= front4_in;
         depth4_ff <= depth4_in;
         mag4_ff   <= mag4_in;
         neg4_ff   <= neg4_in;
         front5_ff <= front4_ff;
         depth5_ff <= depth4_ff;
         neg5_ff   <= neg4_ff;
         mul5_ff   <= mul5_in;
         rem_ff    <= rem_in;
         q_ff      <= q_in;
         sat_ff    <= sat_in;
         neg_ff    <= neg_in;
         front_ff  <= front_in;
         depth_ff  <= depth_in;
         out_ff    <= out_in;
         out_front_ff <= front_ff[QBITS];
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_ff[1], out_ff[0]};
   assign rsp_tuser[0] = out_front_ff;

endmodule

// ===== tb/sv/perspective_world_to_screen_tb.sv =====
`timescale 1ns / 1ps

module perspective_world_to_screen_tb import pwts_pkg::*; ();

   typedef struct packed {
      logic [19:0] screen_x;
      logic [19:0] screen_y;
      logic        in_front;
   } screen_point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // point_x, point_y, point_z, zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // screen_x, screen_y
   logic [0:0]  rsp_tuser;        // in_front
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   perspective_world_to_screen i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // view state as the block should hold it
   logic [59:0] view_origin;
   logic [47:0] view_fwd, view_left, view_up;
   logic [19:0] view_sx, view_sy;
   logic [11:0] view_cx, view_cy;

   logic [63:0]      point_queue[$];
   screen_point_type projected_queue[$];
   int               n_mismatch = 0;
   int               n_requests = 0;
   int               n_results = 0;
   int               n_in_front = 0;
   int               n_phases = 0;
   longint           cycle = 0;
   bit               steady = 1'b0;

   function automatic longint axis_dot(logic [59:0] pt, logic [47:0] axis);
      longint acc, d;
      acc = 0;
      for (int k = 0; k < 3; k++) begin
         d = longint'($signed(pt[20*k +: 20])) - longint'($signed(view_origin[20*k +: 20]));
         acc += d * longint'($signed(axis[16*k +: 16]));
      end
      return acc;
   endfunction

   function automatic logic [19:0] screen_pos(longint comp, longint depth,
                                              logic [19:0] scale, logic [11:0] center);
      logic [127:0] num, den, quo;
      longint q, s;
      num = 128'(comp < 0 ? -comp : comp) * (128'(scale) << 4);
      den = 128'(depth) << 8;
      quo = num / den;
      if (quo >= (128'd1 << 40)) quo = 128'd1 << 40;
      q = longint'(quo[63:0]);
      if (comp < 0) q = -q;
      s = longint'({center, 4'b0000}) - q;
      if (s > 524287) s = 524287;
      if (s < -524288) s = -524288;
      return s[19:0];
   endfunction

   function automatic screen_point_type project_point(logic [59:0] pt);
      screen_point_type r;
      longint depth;
      r = '0;
      depth = axis_dot(pt, view_fwd);
      if (depth > DEPTH_MIN) begin
         r.screen_x = screen_pos(axis_dot(pt, view_left), depth, view_sx, view_cx);
         r.screen_y = screen_pos(axis_dot(pt, view_up), depth, view_sy, view_cy);
         r.in_front = 1'b1;
      end
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (point_queue.size() > 0 && (steady || $urandom_range(99) >= 36)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= point_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= steady || $urandom_range(99) >= 36;
   end

   // monitor
   always @(posedge clock) begin
      screen_point_type got, want;
      cycle <= cycle + 1;
      if (!reset && req_tvalid && req_tready) begin
         projected_queue.push_back(project_point(req_tdata[59:0]));
         n_requests++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[19:0], rsp_tdata[39:20], rsp_tuser[0]};
         n_results++;
         if (projected_queue.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected result %h", got);
         end else begin
            want = projected_queue.pop_front();
            if (want.in_front) n_in_front++;
            if (got !== want) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("mismatch: expected x=%h y=%h f=%b, got x=%h y=%h f=%b",
                           want.screen_x, want.screen_y, want.in_front,
                           got.screen_x, got.screen_y, got.in_front);
            end
         end
      end
      if (cycle > 500000) begin
         $display("timeout");
         $display("perspective_world_to_screen_tb: errors");
         $finish;
      end
   end

   task automatic csr_write(reg_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 6'(idx) << 3;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ORIGIN:   view_origin = value[59:0];
         REG_FORWARD:  view_fwd    = value[47:0];
         REG_LEFT:     view_left   = value[47:0];
         REG_UP:       view_up     = value[47:0];
         REG_SCALE_X:  view_sx     = value[19:0];
         REG_SCALE_Y:  view_sy     = value[19:0];
         REG_CENTER_X: view_cx     = value[11:0];
         REG_CENTER_Y: view_cy     = value[11:0];
         default: ;
      endcase
   endtask

   task automatic set_view(logic [59:0] o, logic [47:0] f, logic [47:0] l, logic [47:0] u,
                           logic [19:0] sx, logic [19:0] sy, logic [11:0] cx, logic [11:0] cy);
      csr_write(REG_ORIGIN, 64'(o));
      csr_write(REG_FORWARD, 64'(f));
      csr_write(REG_LEFT, 64'(l));
      csr_write(REG_UP, 64'(u));
      csr_write(REG_SCALE_X, 64'(sx));
      csr_write(REG_SCALE_Y, 64'(sy));
      csr_write(REG_CENTER_X, 64'(cx));
      csr_write(REG_CENTER_Y, 64'(cy));
   endtask

   task automatic push_point(int x, int y, int z);
      point_queue.push_back({4'b0, 20'(z), 20'(y), 20'(x)});
   endtask

   task automatic drain();
      while (point_queue.size() > 0 || projected_queue.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (40) @(posedge clock);
      n_phases++;
   endtask

   function automatic logic [47:0] rand_axes();
      return {16'($urandom), 16'($urandom), 16'($urandom)};
   endfunction

   // point near the view origin, or anywhere for about one in five, so that most quotients stay in range
   task automatic push_random(int span);
      int x, y, z;
      if ($urandom_range(9) < 2) begin
         push_point($urandom, $urandom, $urandom);
      end else begin
         x = int'($signed(view_origin[19:0]))  + $urandom_range(2 * span) - span;
         y = int'($signed(view_origin[39:20])) + $urandom_range(2 * span) - span;
         z = int'($signed(view_origin[59:40])) + $urandom_range(2 * span) - span;
         push_point(x, y, z);
      end
   endtask

   initial begin
      view_origin = '0;
      view_fwd    = 48'd16384;
      view_left   = 48'd16384 << 16;
      view_up     = 48'd16384 << 32;
      view_sx     = 20'd81920;
      view_sy     = 20'd81920;
      view_cx     = 12'd320;
      view_cy     = 12'd240;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default view: behind, in front, field extremes
      push_point(0, 0, 0);
      push_point(100, 0, 0);
      push_point(-100, 5, 5);
      push_point(10, 3, -4);
      push_point(1, 524287, 0);
      push_point(1, -524288, 0);
      push_point(1, 0, 524287);
      push_point(1, 0, -524288);
      push_point(524287, 524287, 524287);
      push_point(-524288, -524288, -524288);
      push_point(524287, -1, 1);
      drain();

      // tiny forward axis puts the depth threshold at x = 16
      set_view('0, 48'd1, 48'd16384 << 16, 48'd16384 << 32, 20'd256, 20'd256, 12'd0, 12'd0);
      push_point(16, 0, 0);
      push_point(17, 0, 0);
      push_point(17, 1000, -1000);
      push_point(524287, 524287, -524288);
      drain();

      // all-ones extremes, then all-zero
      set_view('1, '1, '1, '1, '1, '1, '1, '1);
      push_point(-524288, 0, 0);
      push_point(524287, 524287, 524287);
      push_point(0, 0, 0);
      push_point(-524288, -524288, -524288);
      push_point(-2, 3, 0);
      drain();
      set_view('0, '0, '0, '0, '0, '0, '0, '0);
      push_point(5, 5, 5);
      drain();

      for (int ph = 0; ph < 13; ph++) begin
         steady = (ph == 6);
         if (ph % 3 == 0)
            set_view({20'($urandom), 20'($urandom), 20'($urandom)},
                     rand_axes(), rand_axes(), rand_axes(),
                     20'($urandom), 20'($urandom), 12'($urandom), 12'($urandom));
         else
            set_view({20'($urandom_range(2000)), 20'($urandom_range(2000)),
                      20'($urandom_range(2000))},
                     {16'($urandom_range(4000)), 16'($urandom_range(4000)),
                      16'(16384 - $urandom_range(3000))},
                     rand_axes(), rand_axes(),
                     20'($urandom_range(1048575)), 20'($urandom_range(200000)),
                     12'($urandom), 12'($urandom));
         for (int i = 0; i < 150; i++) push_random(ph % 2 ? 300 : 100000);
         drain();
      end
      steady = 1'b0;

      $display("%0d points in %0d view settings, %0d results (%0d in front)",
               n_requests, n_phases, n_results, n_in_front);
      if (n_mismatch == 0 && projected_queue.size() == 0) begin
         $display("perspective_world_to_screen_tb: clean");
      end else begin
         $display("%0d mismatches, %0d results missing", n_mismatch, projected_queue.size());
         $display("perspective_world_to_screen_tb: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/pwts_pkg.sv
src/perspective_world_to_screen.sv
tb/sv/perspective_world_to_screen_tb.sv
